// File: rtl/core/skinned_vertex_with_bounds_core_assert.svh
// ----------------------------------------------------------------------------
// skinned vertex core assertion macros
// shared concurrent assertion shorthands, clocked on clk_i, off in reset
// ----------------------------------------------------------------------------
`ifndef SKINNED_VERTEX_WITH_BOUNDS_CORE_ASSERT_SVH
`define SKINNED_VERTEX_WITH_BOUNDS_CORE_ASSERT_SVH

// same-cycle implication
`define SVB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/svb_pkg.sv
// ----------------------------------------------------------------------------
// svb_pkg
// shared types, widths and saturation helpers of the skinned vertex core
// ----------------------------------------------------------------------------
package svb_pkg;

  localparam int unsigned JOINT_COUNT     = 256;
  localparam int unsigned JOINT_AW        = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int unsigned WORDS_PER_JOINT = 12;
  localparam int unsigned COLS            = 4;
  localparam int unsigned ROWS            = 3;

  localparam int unsigned Q_W    = 32;  // q16.16 word
  localparam int unsigned PROD_W = 48;  // q32.32 product floored to q32.16
  localparam int unsigned ROW_W  = 50;  // sum of four products
  localparam int unsigned ACC_W  = 40;  // vertex accumulator
  localparam int unsigned SUM_W  = ROW_W + 1;

  localparam int unsigned IN_TDATA_W  = 176;
  localparam int unsigned OUT_TDATA_W = 288;
  localparam int unsigned IN_TUSER_W  = 2;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CONTRIB = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  // input beat payload, last field first (packed msb first)
  typedef struct packed {
    logic [3:0]            pad;
    logic signed [Q_W-1:0] base_w;
    logic signed [Q_W-1:0] base_z;
    logic signed [Q_W-1:0] base_y;
    logic signed [Q_W-1:0] base_x;
    logic signed [Q_W-1:0] load_value;
    logic [3:0]            element_index;
    logic [7:0]            joint_index;
  } in_beat_t;

  typedef struct packed {
    logic signed [Q_W-1:0] max_z;
    logic signed [Q_W-1:0] max_y;
    logic signed [Q_W-1:0] max_x;
    logic signed [Q_W-1:0] min_z;
    logic signed [Q_W-1:0] min_y;
    logic signed [Q_W-1:0] min_x;
    logic signed [Q_W-1:0] pos_z;
    logic signed [Q_W-1:0] pos_y;
    logic signed [Q_W-1:0] pos_x;
  } out_beat_t;

  // pipeline tag carried alongside the datapath
  typedef struct packed {
    logic       valid;
    logic [1:0] cmd;
    logic       last;
    logic       joint_ok;
  } ctl_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-ACC_W:0] top;
    top = v[SUM_W-1:ACC_W-1];
    if (&top || ~|top) begin
      return v[ACC_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [Q_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-Q_W:0] top;
    top = v[ACC_W-1:Q_W-1];
    if (&top || ~|top) begin
      return v[Q_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/core/svb_ram.sv
// ----------------------------------------------------------------------------
// svb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module svb_ram #(
  parameter int unsigned Width     = 32,
  parameter int unsigned Depth     = 256,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/svb_row.sv
// ----------------------------------------------------------------------------
// svb_row
// one matrix row times the base vector: four multipliers, then a sum stage
// ----------------------------------------------------------------------------
module svb_row
  import svb_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [COLS-1:0][Q_W-1:0]          mat_i,
  input  logic [COLS-1:0][Q_W-1:0]          vec_i,
  output logic signed [ROW_W-1:0]           row_o
);

  logic signed [PROD_W-1:0] prod_q [COLS];
  logic signed [PROD_W-1:0] prod_d [COLS];
  logic signed [ROW_W-1:0]  row_q;
  logic signed [ROW_W-1:0]  row_d;

  // exact q32.32 product, arithmetic shift floors it to q32.16
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      logic signed [2*Q_W-1:0] p;
      p = $signed(mat_i[c]) * $signed(vec_i[c]);
      prod_d[c] = p[2*Q_W-1:16];
    end
  end

  always_comb begin
    row_d = '0;
    for (int c = 0; c < COLS; c++) begin
      row_d = row_d + ROW_W'(prod_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < COLS; c++) begin
        prod_q[c] <= prod_d[c];
      end
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

// File: rtl/core/skinned_vertex_with_bounds_core.sv
// ----------------------------------------------------------------------------
// skinned_vertex_with_bounds_core
// linear blend skinning in q16.16 with a running bounding box
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while the master side keeps up with the results
// a result reaches the master side after the edge that takes the last
//   contribution, through ram read, multiply, row sum, accumulate, bounds
// the pipeline holds only while the one-entry skid register is full
// reset (rst_ni low, asynchronous): pipeline empty, vertex sum and bounds zero;
//   joint matrix words are undefined until loaded
module skinned_vertex_with_bounds_core
  import svb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  // joint_index, element_index, load_value, base_x, base_y, base_z, base_w, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  // cmd
  input  logic [IN_TUSER_W-1:0]  s_tuser_i,
  // last_weight
  input  logic                   s_tlast_i,
  // master side
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  // pos_x, pos_y, pos_z, min_x, min_y, min_z, max_x, max_y, max_z
  output logic [OUT_TDATA_W-1:0] m_tdata_o
);

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  in_beat_t in_beat;
  logic     pipe_en;
  logic     accept;
  logic     in_joint_ok;
  logic     skid_valid_q;

  assign in_beat     = in_beat_t'(s_tdata_i);
  assign pipe_en     = !skid_valid_q;   // whole pipeline moves unless the skid is full
  assign s_tready_o  = pipe_en;
  assign accept      = s_tvalid_i && s_tready_o;
  assign in_joint_ok = 32'(in_beat.joint_index) < JOINT_COUNT;

  // --------------------------------------------------------------------------
  // joint store: one ram per matrix word, so a contribution reads all twelve
  // words of its joint together in the same cycle
  // --------------------------------------------------------------------------
  logic [WORDS_PER_JOINT-1:0][Q_W-1:0] mat_rd;
  logic [JOINT_AW-1:0]                 joint_addr;
  logic                                is_load;
  logic                                is_contrib;

  assign joint_addr = JOINT_AW'(in_beat.joint_index);
  assign is_load    = accept && (s_tuser_i == CMD_LOAD) && in_joint_ok;
  assign is_contrib = accept && (s_tuser_i == CMD_CONTRIB);

  for (genvar k = 0; k < WORDS_PER_JOINT; k++) begin : g_word
    svb_ram #(
      .Width (Q_W),
      .Depth (JOINT_COUNT)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (is_load && (in_beat.element_index == 4'(k))),
      .waddr_i (joint_addr),
      .wdata_i (in_beat.load_value),
      .re_i    (is_contrib),
      .raddr_i (joint_addr),
      .rdata_o (mat_rd[k])
    );
  end

  // --------------------------------------------------------------------------
  // stage 1: beat tag and base vector, aligned with the ram read data
  // --------------------------------------------------------------------------
  ctl_t                     ctl1_q, ctl1_d, ctl2_q, ctl3_q;
  logic [COLS-1:0][Q_W-1:0] vec1_q;

  always_comb begin
    ctl1_d = '0;
    if (accept) begin
      ctl1_d.valid    = 1'b1;
      ctl1_d.cmd      = s_tuser_i;
      ctl1_d.last     = s_tlast_i;
      ctl1_d.joint_ok = in_joint_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vec1_q <= {in_beat.base_w, in_beat.base_z, in_beat.base_y, in_beat.base_x};
    end
  end

  // --------------------------------------------------------------------------
  // stages 2 and 3: per-row multiply and row sum
  // --------------------------------------------------------------------------
  logic signed [ROW_W-1:0] row_sum [ROWS];

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    svb_row u_row (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .mat_i (mat_rd[r*COLS +: COLS]),
      .vec_i (vec1_q),
      .row_o (row_sum[r])
    );
  end

  // --------------------------------------------------------------------------
  // stage 3 to 4: accumulate into the vertex sum, emit position on the last
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] sum_q [ROWS];
  logic signed [ACC_W-1:0] sum_d [ROWS];
  logic signed [Q_W-1:0]   pos4_q [ROWS];
  logic signed [Q_W-1:0]   pos4_d [ROWS];
  logic                    res4_q, res4_d;
  logic                    clr4_q, clr4_d;
  logic                    s3_contrib;

  assign s3_contrib = ctl3_q.valid && (ctl3_q.cmd == CMD_CONTRIB);
  assign res4_d     = s3_contrib && ctl3_q.last;
  assign clr4_d     = ctl3_q.valid && (ctl3_q.cmd == CMD_CLEAR);

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      logic signed [ACC_W-1:0] upd;
      // an out-of-range joint adds nothing
      upd = ctl3_q.joint_ok ? sat_acc(SUM_W'(sum_q[r]) + SUM_W'(row_sum[r])) : sum_q[r];
      pos4_d[r] = sat_pos(upd);
      if (!s3_contrib) begin
        sum_d[r] = sum_q[r];
      end else if (ctl3_q.last) begin
        sum_d[r] = '0;
      end else begin
        sum_d[r] = upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      res4_q <= 1'b0;
      clr4_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        sum_q[r] <= '0;
      end
    end else if (pipe_en) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      res4_q <= res4_d;
      clr4_q <= clr4_d;
      for (int r = 0; r < ROWS; r++) begin
        sum_q[r] <= sum_d[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && res4_d) begin
      for (int r = 0; r < ROWS; r++) begin
        pos4_q[r] <= pos4_d[r];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: widen the bounds (zero them on a clear), build the result beat
  // --------------------------------------------------------------------------
  logic signed [Q_W-1:0] lo_q [ROWS];
  logic signed [Q_W-1:0] hi_q [ROWS];
  logic signed [Q_W-1:0] lo_new [ROWS];
  logic signed [Q_W-1:0] hi_new [ROWS];
  out_beat_t             res_beat;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      lo_new[r] = (pos4_q[r] < lo_q[r]) ? pos4_q[r] : lo_q[r];
      hi_new[r] = (pos4_q[r] > hi_q[r]) ? pos4_q[r] : hi_q[r];
    end
    res_beat.pos_x = pos4_q[0];
    res_beat.pos_y = pos4_q[1];
    res_beat.pos_z = pos4_q[2];
    res_beat.min_x = lo_new[0];
    res_beat.min_y = lo_new[1];
    res_beat.min_z = lo_new[2];
    res_beat.max_x = hi_new[0];
    res_beat.max_y = hi_new[1];
    res_beat.max_z = hi_new[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        lo_q[r] <= '0;
        hi_q[r] <= '0;
      end
    end else if (pipe_en) begin
      priority if (clr4_q) begin
        for (int r = 0; r < ROWS; r++) begin
          lo_q[r] <= '0;
          hi_q[r] <= '0;
        end
      end else if (res4_q) begin
        for (int r = 0; r < ROWS; r++) begin
          lo_q[r] <= lo_new[r];
          hi_q[r] <= hi_new[r];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register plus one skid entry, so a stalled master side costs the
  // slave side nothing until a second result is waiting
  // --------------------------------------------------------------------------
  out_beat_t out_q, skid_q;
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_d;
  logic      out_pop;
  logic      load_out_res, load_out_skid, load_skid;

  assign out_pop = out_valid_q && m_tready_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out_res  = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_valid_q) begin
      if (out_pop) begin
        load_out_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (res4_q) begin
      if (!out_valid_q || out_pop) begin
        load_out_res = 1'b1;
        out_valid_d  = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_res) begin
      out_q <= res_beat;
    end else if (load_out_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= res_beat;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`include "skinned_vertex_with_bounds_core_assert.svh"

  `SVB_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `SVB_ASSERT_NXT(a_skid_holds, skid_valid_q && !m_tready_i, skid_valid_q, "skid beat lost")
  `SVB_ASSERT_NXT(a_sum_cleared, pipe_en && s3_contrib && ctl3_q.last,
                  sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0,
                  "vertex sum not cleared after last contribution")
  `SVB_ASSERT_IMP(a_origin_inside, 1'b1,
                  lo_q[0] <= 0 && lo_q[1] <= 0 && lo_q[2] <= 0 &&
                  hi_q[0] >= 0 && hi_q[1] >= 0 && hi_q[2] >= 0,
                  "bounds exclude the origin")

endmodule
